// ===== src/twvt_pkg.sv =====
// Shared types and constants for the tilt wall vertex transform.
// No dependencies; compiled first.
package twvt_pkg;

    localparam int GAIN_Q16  = 39797;
    localparam int DIV_STEPS = 16;

    typedef enum logic [2:0] {
        REG_VERT_X,
        REG_VERT_Y,
        REG_ACCEL_LIM,
        REG_SENS_MIN,
        REG_SENS_MAX,
        REG_WALL_MIN,
        REG_WALL_MAX,
        REG_ORIGIN
    } cfg_index_t;

    typedef enum logic [1:0] {
        OFF_MIN,
        OFF_MAX,
        OFF_DIV
    } off_sel_t;

    typedef logic signed [19:0] vec_t;
    typedef logic signed [20:0] vtx_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        off_sel_t           sel;
        logic               at_min;
        logic               neg;
        logic        [14:0] wabs;
        logic        [15:0] dd;
        logic        [15:0] den;
        logic        [14:0] wmin;
        logic        [14:0] wmax;
        logic        [31:0] sq_x;
        logic        [31:0] sq_y;
        logic        [29:0] lim_sq;
    } prep_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        off_sel_t           sel;
        logic               at_min;
        logic               vis;
        logic               neg;
        logic        [14:0] wmin;
        logic        [14:0] wmax;
        logic        [16:0] rem;
        logic        [15:0] num_lo;
        logic        [16:0] den2;
        logic        [15:0] quo;
    } div_t;

    typedef struct packed {
        logic               valid;
        logic        [1:0]  vidx;
        logic               last;
        logic               vis;
        logic               at_min;
        logic               zero;
        vec_t               vec_x;
        vec_t               vec_y;
        vtx_t               px;
        vtx_t               py;
    } cord_t;

    typedef struct packed {
        logic               valid;
        logic        [1:0]  vidx;
        logic               last;
        logic               vis;
        logic               at_min;
        logic               zero;
        vtx_t               px;
        vtx_t               py;
        logic signed [37:0] gx;
        logic signed [37:0] gy;
    } gain_t;

endpackage

// ===== src/twvt_sample_if.sv =====
// Input channel of the tilt wall vertex transform: one sensor sample per item.
// Stands alone; compiled after twvt_pkg.
interface twvt_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic        [15:0] sensor_distance;

    modport source (output valid, accel_x, accel_y, sensor_distance, input ready);
    modport sink   (input valid, accel_x, accel_y, sensor_distance, output ready);
endinterface

// ===== src/twvt_result_if.sv =====
// Output channel of the tilt wall vertex transform: one screen vertex per item.
// Stands alone; compiled after twvt_pkg.
interface twvt_result_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  vertex_index;
    logic signed [10:0] screen_x;
    logic signed [10:0] screen_y;
    logic               visible;
    logic               at_min_distance;
    logic               last_vertex;

    modport source (output valid, vertex_index, screen_x, screen_y, visible,
                    at_min_distance, last_vertex, input ready);
    modport sink   (input valid, vertex_index, screen_x, screen_y, visible,
                    at_min_distance, last_vertex, output ready);
endinterface

// ===== src/tilt_wall_vertex_transform_core.sv =====
// Top level of the tilt wall vertex transform.
// Depends on twvt_pkg, twvt_sample_if and twvt_result_if.

// Each sample item carries a tilt reading and a range-sensor distance and yields
// VERTEX_COUNT result items, one per wall vertex, in vertex order with the last
// one flagged. The distance is clamped and mapped to a pixel offset through a
// pipelined restoring divider (one quotient bit per stage), each vertex is then
// rotated by atan2(-ax, ay) with a CORDIC of CORDIC_STEPS stages that runs the
// vectoring and rotation side by side, scaled by the CORDIC gain, rounded and
// placed at the screen origin. The result side delivers one vertex per cycle
// while it is not stalled, and a new sample is taken only when the holding
// register that expands one sample into its vertices is empty or emits its
// final vertex. The CORDIC, gain and output stages advance whenever the
// output register is empty or being drained; the stages up to the holding
// register also wait for it to free up. A stall on the result side thus
// freezes every stage and nothing is lost or repeated. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and must
// only change while no item is in flight.
module tilt_wall_vertex_transform_core #(
    parameter int VERTEX_COUNT = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  twvt_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    twvt_sample_if.sink          sample,
    twvt_result_if.source        result
);
    import twvt_pkg::*;

    localparam logic [1:0] LAST_IDX = 2'(VERTEX_COUNT - 1);

    // Configuration registers.
    logic [31:0] vert_x_reg, vert_y_reg;
    logic [14:0] accel_lim_reg, wall_min_reg, wall_max_reg;
    logic [15:0] sens_min_reg, sens_max_reg, origin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_x_reg    <= '0;
            vert_y_reg    <= '0;
            accel_lim_reg <= 15'd256;
            sens_min_reg  <= 16'd640;
            sens_max_reg  <= 16'd12800;
            wall_min_reg  <= 15'd1280;
            wall_max_reg  <= 15'd7680;
            origin_reg    <= 16'd8256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERT_X:    vert_x_reg    <= cfg_data;
                REG_VERT_Y:    vert_y_reg    <= cfg_data;
                REG_ACCEL_LIM: accel_lim_reg <= cfg_data[14:0];
                REG_SENS_MIN:  sens_min_reg  <= cfg_data[15:0];
                REG_SENS_MAX:  sens_max_reg  <= cfg_data[15:0];
                REG_WALL_MIN:  wall_min_reg  <= cfg_data[14:0];
                REG_WALL_MAX:  wall_max_reg  <= cfg_data[14:0];
                REG_ORIGIN:    origin_reg    <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Global advance: the CORDIC and output stages move when the output register can take data.
    logic       out_valid_reg;
    logic       adv;
    logic       hold_valid_reg;
    logic [1:0] cnt_reg;
    logic       fe_adv;

    assign adv    = !out_valid_reg || result.ready;
    // The front end moves only when the holding register is empty or emits
    // its final vertex in this cycle.
    assign fe_adv = adv && (!hold_valid_reg || cnt_reg == LAST_IDX);
    assign sample.ready = fe_adv;

    // Stage 1: clamp decisions, differences and squares.
    prep_t prep_reg, prep_next;
    logic signed [15:0] wdiff;

    always_comb
    begin
        prep_next        = prep_reg;
        prep_next.valid  = sample.valid;
        prep_next.ax     = sample.accel_x;
        prep_next.ay     = sample.accel_y;
        prep_next.at_min = sample.sensor_distance < sens_min_reg;
        priority if (sample.sensor_distance < sens_min_reg)
            prep_next.sel = OFF_MIN;
        else if (sample.sensor_distance > sens_max_reg)
            prep_next.sel = OFF_MAX;
        else if (sens_max_reg == sens_min_reg)
            prep_next.sel = OFF_MIN;
        else
            prep_next.sel = OFF_DIV;
        wdiff            = $signed({1'b0, wall_max_reg}) - $signed({1'b0, wall_min_reg});
        prep_next.neg    = wdiff[15];
        prep_next.wabs   = wdiff[15] ? 15'(-wdiff) : wdiff[14:0];
        prep_next.dd     = sample.sensor_distance - sens_min_reg;
        prep_next.den    = sens_max_reg - sens_min_reg;
        prep_next.wmin   = wall_min_reg;
        prep_next.wmax   = wall_max_reg;
        prep_next.sq_x   = 32'($signed(sample.accel_x) * $signed(sample.accel_x));
        prep_next.sq_y   = 32'($signed(sample.accel_y) * $signed(sample.accel_y));
        prep_next.lim_sq = accel_lim_reg * accel_lim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg.valid <= 1'b0;
        else if (fe_adv)
            prep_reg <= prep_next;
    end

    // Stage 2: numerator product and visibility compare; divider setup.
    // The rounded quotient is floor((2n + den) / (2 den)), below 2^16.
    div_t div_reg [0:DIV_STEPS];
    div_t div0_next;
    logic [30:0] prod;
    logic [32:0] numer;

    always_comb
    begin
        prod             = prep_reg.wabs * prep_reg.dd;
        numer            = {1'b0, prod, 1'b0} + 33'(prep_reg.den);
        div0_next.valid  = prep_reg.valid;
        div0_next.ax     = prep_reg.ax;
        div0_next.ay     = prep_reg.ay;
        div0_next.sel    = prep_reg.sel;
        div0_next.at_min = prep_reg.at_min;
        div0_next.vis    = (33'(prep_reg.sq_x) + 33'(prep_reg.sq_y)) >= 33'(prep_reg.lim_sq);
        div0_next.neg    = prep_reg.neg;
        div0_next.wmin   = prep_reg.wmin;
        div0_next.wmax   = prep_reg.wmax;
        div0_next.rem    = numer[32:16];
        div0_next.num_lo = numer[15:0];
        div0_next.den2   = {prep_reg.den, 1'b0};
        div0_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg[0].valid <= 1'b0;
        else if (fe_adv)
            div_reg[0] <= div0_next;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        div_t        nxt;
        logic [17:0] trial;
        logic        ge;

        always_comb
        begin
            trial      = {div_reg[k].rem, div_reg[k].num_lo[15]};
            ge         = trial >= {1'b0, div_reg[k].den2};
            nxt        = div_reg[k];
            nxt.rem    = ge ? 17'(trial - {1'b0, div_reg[k].den2}) : trial[16:0];
            nxt.num_lo = {div_reg[k].num_lo[14:0], 1'b0};
            nxt.quo    = {div_reg[k].quo[14:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[k + 1].valid <= 1'b0;
            else if (fe_adv)
                div_reg[k + 1] <= nxt;
        end
    end

    // Holding register: offset is finished here and the sample is spread
    // over its vertices, one per cycle while the result side does not stall.
    div_t div_last;
    logic signed [16:0] off_div;
    logic        [14:0] off_next;
    logic signed [15:0] hold_ax_reg, hold_ay_reg;
    logic        [14:0] hold_off_reg;
    logic               hold_vis_reg, hold_min_reg;

    always_comb
    begin
        div_last = div_reg[DIV_STEPS];
        off_div  = div_last.neg ? $signed({2'b00, div_last.wmin}) - $signed({1'b0, div_last.quo})
                                : $signed({2'b00, div_last.wmin}) + $signed({1'b0, div_last.quo});
        unique case (div_last.sel)
            OFF_MIN: off_next = div_last.wmin;
            OFF_MAX: off_next = div_last.wmax;
            OFF_DIV: off_next = off_div[14:0];
            default: off_next = div_last.wmin;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (fe_adv)
        begin
            hold_valid_reg <= div_last.valid;
            cnt_reg        <= '0;
        end
        else if (adv && hold_valid_reg)
            cnt_reg <= cnt_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (fe_adv)
        begin
            hold_ax_reg  <= div_last.ax;
            hold_ay_reg  <= div_last.ay;
            hold_off_reg <= off_next;
            hold_vis_reg <= div_last.vis;
            hold_min_reg <= div_last.at_min;
        end
    end

    // CORDIC entry: vertex in Q8.8, vector (ay, -ax), half-turn flip when ay < 0.
    cord_t cord_reg [0:CORDIC_STEPS];
    cord_t cord0_next;
    logic signed [7:0] vx_b, vy_b;
    vtx_t vx0, vy0;
    vec_t ex, ey;
    logic flip;

    always_comb
    begin
        vx_b  = vert_x_reg[{cnt_reg, 3'b000} +: 8];
        vy_b  = vert_y_reg[{cnt_reg, 3'b000} +: 8];
        vx0   = vtx_t'($signed({vx_b, 8'h00}));
        vy0   = vtx_t'($signed({vy_b, 8'h00})) + vtx_t'({1'b0, hold_off_reg});
        ex    = vec_t'(hold_ay_reg);
        ey    = -vec_t'(hold_ax_reg);
        flip  = hold_ay_reg[15];
        cord0_next.valid  = hold_valid_reg;
        cord0_next.vidx   = cnt_reg;
        cord0_next.last   = cnt_reg == LAST_IDX;
        cord0_next.vis    = hold_vis_reg;
        cord0_next.at_min = hold_min_reg;
        cord0_next.zero   = (hold_ax_reg == '0) && (hold_ay_reg == '0);
        cord0_next.vec_x  = flip ? -ex : ex;
        cord0_next.vec_y  = flip ? -ey : ey;
        cord0_next.px     = flip ? -vx0 : vx0;
        cord0_next.py     = flip ? -vy0 : vy0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cord_reg[0].valid <= 1'b0;
        else if (adv)
            cord_reg[0] <= cord0_next;
    end

    // One CORDIC iteration per stage; the direction chosen by the vector also
    // drives the vertex rotation. A zero tilt leaves the vertex untouched.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cord
        cord_t nxt;
        vec_t  sx, sy;
        vtx_t  tx, ty;

        always_comb
        begin
            sx  = cord_reg[i].vec_x >>> i;
            sy  = cord_reg[i].vec_y >>> i;
            tx  = cord_reg[i].px >>> i;
            ty  = cord_reg[i].py >>> i;
            nxt = cord_reg[i];
            if (!cord_reg[i].vec_y[19])
            begin
                nxt.vec_x = cord_reg[i].vec_x + sy;
                nxt.vec_y = cord_reg[i].vec_y - sx;
                if (!cord_reg[i].zero)
                begin
                    nxt.px = cord_reg[i].px - ty;
                    nxt.py = cord_reg[i].py + tx;
                end
            end
            else
            begin
                nxt.vec_x = cord_reg[i].vec_x - sy;
                nxt.vec_y = cord_reg[i].vec_y + sx;
                if (!cord_reg[i].zero)
                begin
                    nxt.px = cord_reg[i].px + ty;
                    nxt.py = cord_reg[i].py - tx;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cord_reg[i + 1].valid <= 1'b0;
            else if (adv)
                cord_reg[i + 1] <= nxt;
        end
    end

    // Gain correction.
    gain_t gain_reg;
    cord_t cord_last;
    assign cord_last = cord_reg[CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg.valid <= 1'b0;
        else if (adv)
        begin
            gain_reg.valid  <= cord_last.valid;
            gain_reg.vidx   <= cord_last.vidx;
            gain_reg.last   <= cord_last.last;
            gain_reg.vis    <= cord_last.vis;
            gain_reg.at_min <= cord_last.at_min;
            gain_reg.zero   <= cord_last.zero;
            gain_reg.px     <= cord_last.px;
            gain_reg.py     <= cord_last.py;
            gain_reg.gx     <= 38'(cord_last.px * $signed(18'(GAIN_Q16)));
            gain_reg.gy     <= 38'(cord_last.py * $signed(18'(GAIN_Q16)));
        end
    end

    // Rounding half away from zero, then translation with y flipped.
    function automatic logic signed [15:0] round24(input logic signed [37:0] v);
        logic [37:0] mag;
        logic [37:0] r;
        begin
            mag = v[37] ? 38'(-v) : v;
            r   = (mag + 38'd8388608) >> 24;
            round24 = v[37] ? -$signed(r[15:0]) : $signed(r[15:0]);
        end
    endfunction

    function automatic logic signed [15:0] round8(input vtx_t v);
        logic [20:0] mag;
        logic [20:0] r;
        begin
            mag = v[20] ? 21'(-v) : v;
            r   = (mag + 21'd128) >> 8;
            round8 = v[20] ? -$signed(r[15:0]) : $signed(r[15:0]);
        end
    endfunction

    logic signed [15:0] rx, ry, scr_x, scr_y;
    logic [1:0]  vidx_reg;
    logic signed [10:0] scr_x_reg, scr_y_reg;
    logic        vis_reg, min_reg, last_reg;

    always_comb
    begin
        rx    = gain_reg.zero ? round8(gain_reg.px) : round24(gain_reg.gx);
        ry    = gain_reg.zero ? round8(gain_reg.py) : round24(gain_reg.gy);
        scr_x = $signed({8'h00, origin_reg[7:0]}) + rx;
        scr_y = $signed({8'h00, origin_reg[15:8]}) - ry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= gain_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vidx_reg  <= gain_reg.vidx;
            scr_x_reg <= scr_x[10:0];
            scr_y_reg <= scr_y[10:0];
            vis_reg   <= gain_reg.vis;
            min_reg   <= gain_reg.at_min;
            last_reg  <= gain_reg.last;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.vertex_index    = vidx_reg;
    assign result.screen_x        = scr_x_reg;
    assign result.screen_y        = scr_y_reg;
    assign result.visible         = vis_reg;
    assign result.at_min_distance = min_reg;
    assign result.last_vertex     = last_reg;

    // The final vertex of a sample always carries the top index.
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last_vertex |-> result.vertex_index == LAST_IDX)
        else $error("last vertex flag on wrong index");

    // The vertex counter never runs past the vertex count.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> cnt_reg <= LAST_IDX)
        else $error("vertex counter out of range");

    // A sample is only taken when the holding register frees up.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready && hold_valid_reg |-> cnt_reg == LAST_IDX)
        else $error("sample taken while vertices remain");

    // A stalled result side freezes the CORDIC entry.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cord_reg[0].valid))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/tb_tilt_wall_vertex_transform_core.sv =====
// Testbench for tilt_wall_vertex_transform_core: directed and random samples are
// checked vertex by vertex against a predictor in this file or typed expectations.
// Depends on twvt_pkg, twvt_sample_if, twvt_result_if and the core itself.
`timescale 1ns / 100ps

module tb_tilt_wall_vertex_transform_core;
    import twvt_pkg::*;

    localparam int VCOUNT     = 4;
    localparam int CSTEPS     = 16;
    localparam int RX_LATENCY = CSTEPS + 21;
    localparam int CYCLE_CAP  = 200000;
    localparam int LONG_HOLD  = 400;

    // One vertex of a transformed sample, as the result channel carries it.
    typedef struct {
        logic [1:0]  vidx;
        logic [10:0] sx;
        logic [10:0] sy;
        logic        vis;
        logic        at_min;
        logic        last;
    } screen_vertex_t;

    // One row of the directed plan: either a register write or a sample.
    // Where typed is set, every vertex of the sample is expected at (sx, sy).
    typedef struct {
        bit                 is_cfg;
        cfg_index_t         idx;
        logic        [31:0] data;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic        [15:0] distance;
        bit                 typed;
        logic        [10:0] sx;
        logic        [10:0] sy;
        logic               vis;
        logic               at_min;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = REG_VERT_X;
    logic [31:0] cfg_data = '0;

    twvt_sample_if smp();
    twvt_result_if res();

    // Shadow copy of the configuration, updated on every register write.
    logic [31:0] sh_vx, sh_vy;
    logic [14:0] sh_alim, sh_wmin, sh_wmax;
    logic [15:0] sh_smin, sh_smax, sh_origin;

    screen_vertex_t pending_vertices[$];
    plan_row_t      plan[$];
    int             mismatches = 0;
    int             cycles = 0;
    int             hold_requests = 0;
    int             holds_served = 0;

    tilt_wall_vertex_transform_core #(
        .VERTEX_COUNT(VCOUNT),
        .CORDIC_STEPS(CSTEPS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sample   (smp),
        .result   (res)
    );

    always #4 clk = ~clk;

    initial
    begin
        smp.valid           = 1'b0;
        smp.accel_x         = '0;
        smp.accel_y         = '0;
        smp.sensor_distance = '0;
        res.ready           = 1'b0;
    end

    // The run is reported as failed and stopped once the cycle counter passes its cap.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Magnitude rounding with ties away from zero, for a right shift by frac.
    function automatic longint round_shift(longint p, int frac);
        longint mag;
        longint r;
        mag = (p < 0) ? -p : p;
        r = (mag + (longint'(1) <<< (frac - 1))) >>> frac;
        return (p < 0) ? -r : r;
    endfunction

    // Division with the quotient rounded half away from zero.
    function automatic longint ratio_rounded(longint num, longint den);
        longint n;
        longint dd;
        longint q;
        n  = (num < 0) ? -num : num;
        dd = (den < 0) ? -den : den;
        q  = (2 * n + dd) / (2 * dd);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Works out the screen vertices of one sample under the shadow configuration
    // and appends them to the queue of vertices still to come.
    function automatic void predict_screen_vertices(logic signed [15:0] ax_in,
                                                    logic signed [15:0] ay_in,
                                                    logic [15:0] dist_in);
        longint ax, ay, d, offset, vx, vy, nx, ny, px, py, rx, ry;
        longint ox, oy;
        bit     at_min, vis, flip, zero;
        bit     ccw[CSTEPS];
        screen_vertex_t v;
        ax = longint'(ax_in);
        ay = longint'(ay_in);
        d  = longint'(dist_in);
        ox = longint'(sh_origin[7:0]);
        oy = longint'(sh_origin[15:8]);
        at_min = 1'b0;

        // Distance clamp and linear map onto the pixel offset.
        if (d < longint'(sh_smin))
        begin
            offset = longint'(sh_wmin);
            at_min = 1'b1;
        end
        else if (d > longint'(sh_smax))
            offset = longint'(sh_wmax);
        else if (sh_smax == sh_smin)
            offset = longint'(sh_wmin);
        else
            offset = longint'(sh_wmin) + ratio_rounded(
                (longint'(sh_wmax) - longint'(sh_wmin)) * (d - longint'(sh_smin)),
                longint'(sh_smax) - longint'(sh_smin));

        vis  = (ax * ax + ay * ay) >= longint'(sh_alim) * longint'(sh_alim);
        zero = (ax == 0) && (ay == 0);

        // Vectoring pass: the tilt vector is folded into the right half plane
        // and driven onto the x axis, recording each step's direction.
        vx = ay;
        vy = -ax;
        flip = vx < 0;
        if (flip)
        begin
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < CSTEPS; i++)
        begin
            ccw[i] = vy < 0;
            if (!ccw[i])
            begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
            end
            else
            begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
            end
            vx = nx;
            vy = ny;
        end

        // Rotation pass: each vertex replays the same directions.
        for (int k = 0; k < VCOUNT; k++)
        begin
            px = longint'($signed(sh_vx[8*k +: 8])) * 256;
            py = longint'($signed(sh_vy[8*k +: 8])) * 256 + offset;
            if (zero)
            begin
                rx = round_shift(px, 8);
                ry = round_shift(py, 8);
            end
            else
            begin
                if (flip)
                begin
                    px = -px;
                    py = -py;
                end
                for (int i = 0; i < CSTEPS; i++)
                begin
                    if (ccw[i])
                    begin
                        nx = px + (py >>> i);
                        ny = py - (px >>> i);
                    end
                    else
                    begin
                        nx = px - (py >>> i);
                        ny = py + (px >>> i);
                    end
                    px = nx;
                    py = ny;
                end
                rx = round_shift(px * GAIN_Q16, 24);
                ry = round_shift(py * GAIN_Q16, 24);
            end
            v.vidx   = 2'(k);
            v.sx     = 11'(ox + rx);
            v.sy     = 11'(oy - ry);
            v.vis    = vis;
            v.at_min = at_min;
            v.last   = (k == VCOUNT - 1);
            pending_vertices.push_back(v);
        end
    endfunction

    // Result checker: every accepted vertex is matched against the oldest one
    // still pending.
    always @(posedge clk)
    begin
        screen_vertex_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: vertex %0d arrived with none pending", $realtime,
                             res.vertex_index);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (res.vertex_index !== want.vidx || res.screen_x !== want.sx ||
                    res.screen_y !== want.sy || res.visible !== want.vis ||
                    res.at_min_distance !== want.at_min ||
                    res.last_vertex !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: got idx=%0d x=%0d y=%0d vis=%b min=%b last=%b, want idx=%0d x=%0d y=%0d vis=%b min=%b last=%b",
                                 $realtime, res.vertex_index, res.screen_x,
                                 res.screen_y, res.visible, res.at_min_distance,
                                 res.last_vertex, want.vidx, $signed(want.sx),
                                 $signed(want.sy), want.vis, want.at_min, want.last);
                end
            end
        end
    end

    // Receiver: a repeating pattern of free flow, a fixed stall
    // rhythm and random stalls. A hold request from the stimulus process
    // freezes it for a long stretch so the pipeline backs up into the input.
    always @(posedge clk)
    begin : receiver
        int   hold_left;
        logic [6:0] beat;
        if (!rst_n)
        begin
            hold_left = 0;
            beat      = '0;
            res.ready <= 1'b0;
        end
        else
        begin
            beat = beat + 1'b1;
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (beat < 7'd40)
                res.ready <= 1'b1;
            else if (beat < 7'd72)
                res.ready <= (beat[2:0] != 3'd0) && (beat[2:0] != 3'd3);
            else
                res.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Register write; the caller lowers cfg_we once the last write is done so
    // that it is never lowered and raised within one step.
    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_VERT_X:    sh_vx     = value;
            REG_VERT_Y:    sh_vy     = value;
            REG_ACCEL_LIM: sh_alim   = value[14:0];
            REG_SENS_MIN:  sh_smin   = value[15:0];
            REG_SENS_MAX:  sh_smax   = value[15:0];
            REG_WALL_MIN:  sh_wmin   = value[14:0];
            REG_WALL_MAX:  sh_wmax   = value[14:0];
            REG_ORIGIN:    sh_origin = value[15:0];
            default: ;
        endcase
    endtask

    // Drops valid and waits until every pending vertex has arrived, then a
    // little longer so the block is fully idle.
    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offers one sample and holds it until the block takes it.
    task automatic offer_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic [15:0] distance);
        smp.valid           <= 1'b1;
        smp.accel_x         <= ax;
        smp.accel_y         <= ay;
        smp.sensor_distance <= distance;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
    endtask

    // Writes all eight registers, the phase's configuration.
    task automatic load_config(logic [31:0] vx, logic [31:0] vy, logic [14:0] alim,
                               logic [15:0] smin, logic [15:0] smax,
                               logic [14:0] wmin, logic [14:0] wmax,
                               logic [15:0] origin);
        drain();
        write_reg(REG_VERT_X, vx);
        write_reg(REG_VERT_Y, vy);
        write_reg(REG_ACCEL_LIM, {17'd0, alim});
        write_reg(REG_SENS_MIN, {16'd0, smin});
        write_reg(REG_SENS_MAX, {16'd0, smax});
        write_reg(REG_WALL_MIN, {17'd0, wmin});
        write_reg(REG_WALL_MAX, {17'd0, wmax});
        write_reg(REG_ORIGIN, {16'd0, origin});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void plan_item(int ax, int ay, int distance);
        plan.push_back('{is_cfg: 1'b0, idx: REG_VERT_X, data: '0, ax: 16'(ax),
                         ay: 16'(ay), distance: 16'(distance), typed: 1'b0, sx: '0,
                         sy: '0, vis: 1'b0, at_min: 1'b0});
    endfunction

    function automatic void plan_typed(int ax, int ay, int distance, int sx, int sy,
                                       bit vis, bit at_min);
        plan.push_back('{is_cfg: 1'b0, idx: REG_VERT_X, data: '0, ax: 16'(ax),
                         ay: 16'(ay), distance: 16'(distance), typed: 1'b1,
                         sx: 11'(sx), sy: 11'(sy), vis: vis, at_min: at_min});
    endfunction

    function automatic void plan_write(cfg_index_t idx, logic [31:0] value);
        plan.push_back('{is_cfg: 1'b1, idx: idx, data: value, ax: '0, ay: '0,
                         distance: '0, typed: 1'b0, sx: '0, sy: '0, vis: 1'b0,
                         at_min: 1'b0});
    endfunction

    // Random tilt: full range, near zero, exactly zero, or at either extreme.
    function automatic logic signed [15:0] random_tilt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 16'($signed($urandom_range(0, 1023)) - 512);
            3:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random distance: mostly around the configured span, sometimes anywhere.
    function automatic logic [15:0] random_distance();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return sh_smin - 16'($urandom_range(0, 3));
            2:       return sh_smax + 16'($urandom_range(0, 3));
            default: return (sh_smin <= sh_smax) ?
                            16'($urandom_range(sh_smin, sh_smax)) : 16'($urandom);
        endcase
    endfunction

    // Random phase: samples sent in bursts with gaps, and optionally with a long
    // receiver hold or a full pause of the sender part way through.
    task automatic random_phase(int count, bit long_hold, bit full_pause);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (long_hold && n == 4)
                hold_requests++;
            if (full_pause && n == count / 2)
                drain();
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                begin
                    smp.valid <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
            end
            burst--;
            offer_sample(random_tilt(), random_tilt(), random_distance());
            predict_screen_vertices(smp.accel_x, smp.accel_y, smp.sensor_distance);
        end
    endtask

    initial
    begin : stimulus
        plan_row_t row;
        screen_vertex_t v;

        sh_vx = '0; sh_vy = '0; sh_alim = 15'd256;
        sh_smin = 16'd640; sh_smax = 16'd12800;
        sh_wmin = 15'd1280; sh_wmax = 15'd7680; sh_origin = 16'd8256;

        // Reset values: all vertices sit at the origin, so with no tilt the
        // screen point is (64, 32) moved up by the whole-pixel offset.
        plan_typed(0, 0, 0, 64, 27, 1'b0, 1'b1);
        plan_typed(0, 0, 16'hffff, 64, 2, 1'b0, 1'b0);
        plan_item(32767, 0, 640);
        plan_item(-32768, 0, 12800);
        plan_item(0, 32767, 6720);
        plan_item(0, -32768, 100);
        plan_item(-32768, -32768, 65535);
        plan_item(32767, 32767, 12801);
        plan_item(256, 0, 639);
        plan_item(255, 0, 641);
        plan_item(1, 0, 7000);
        plan_write(REG_VERT_X, 32'h807f01ff);
        plan_write(REG_VERT_Y, 32'h7f80ff01);
        plan_item(100, -200, 3000);
        plan_item(-300, 50, 9000);
        plan_item(0, 0, 5000);
        plan_item(-1, -1, 20000);
        plan_item(12000, -9000, 640);
        // Empty sensor span: a distance inside it maps to the low end of the offset.
        plan_write(REG_SENS_MIN, 32'd1000);
        plan_write(REG_SENS_MAX, 32'd1000);
        plan_item(700, 700, 1000);
        plan_item(700, 700, 999);
        plan_item(700, 700, 1001);
        // Reversed offset range maps with a negative slope.
        plan_write(REG_SENS_MAX, 32'd9000);
        plan_write(REG_WALL_MIN, 32'd7000);
        plan_write(REG_WALL_MAX, 32'd100);
        plan_item(-512, 900, 5000);
        plan_item(900, -512, 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[r])
        begin
            row = plan[r];
            if (row.is_cfg)
            begin
                drain();
                write_reg(row.idx, row.data);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                offer_sample(row.ax, row.ay, row.distance);
                if (row.typed)
                begin
                    for (int k = 0; k < VCOUNT; k++)
                    begin
                        v.vidx = 2'(k);
                        v.sx = row.sx;
                        v.sy = row.sy;
                        v.vis = row.vis;
                        v.at_min = row.at_min;
                        v.last = (k == VCOUNT - 1);
                        pending_vertices.push_back(v);
                    end
                end
                else
                    predict_screen_vertices(row.ax, row.ay, row.distance);
            end
        end

        // Random phases, each under its own configuration, extremes included.
        load_config($urandom, $urandom, 15'($urandom_range(0, 2000)), 16'd500,
                    16'd20000, 15'd300, 15'd9000, 16'($urandom));
        random_phase(35, 1'b1, 1'b0);
        load_config(32'h7f7f7f7f, 32'h80808080, 15'h7fff, 16'd0, 16'hffff,
                    15'h7fff, 15'd0, 16'hffff);
        random_phase(30, 1'b0, 1'b1);
        load_config(32'h80808080, 32'h7f7f7f7f, 15'd0, 16'hffff, 16'hffff,
                    15'd0, 15'h7fff, 16'h0000);
        random_phase(30, 1'b0, 1'b0);
        load_config($urandom, $urandom, 15'($urandom), 16'($urandom_range(0, 30000)),
                    16'($urandom_range(30000, 65535)), 15'($urandom), 15'($urandom),
                    16'($urandom));
        random_phase(40, 1'b1, 1'b0);
        load_config($urandom, $urandom, 15'($urandom_range(100, 600)), 16'd640,
                    16'd12800, 15'd1280, 15'd7680, 16'd8256);
        random_phase(24, 1'b0, 1'b0);
        load_config($urandom, $urandom, 15'($urandom), 16'($urandom), 16'($urandom),
                    15'($urandom), 15'($urandom), 16'($urandom));
        random_phase(30, 1'b0, 1'b0);

        // Let everything drain, then allow the pipeline latency for strays.
        drain();
        repeat (RX_LATENCY * 2) @(posedge clk);

        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
